/* hw/rtl/cfl_pkg.sv */
// shared types, constants and the crc step for the framed command link
package cfl_pkg;

  localparam int RX_MAX      = 48;
  localparam int TX_MAX      = 9;
  localparam int RX_CNT_W    = 6;
  localparam int TX_CNT_W    = 4;
  localparam int RX_IDX_W    = $clog2(RX_MAX);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef enum logic [1:0] {
    CMD_BEGIN   = 2'd0,
    CMD_DATA    = 2'd1,
    CMD_RXBYTE  = 2'd2,
    CMD_TIMEOUT = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_TX     = 2'd0,
    KIND_REPLY  = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TIMEOUT = 2'd1,
    ST_CRC     = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_SEND   = 2'd1,
    PH_RXDATA = 2'd2,
    PH_RXCRC  = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    F_IDLE,
    F_EXEC,
    F_OPC,
    F_CRCH,
    F_CRCL,
    F_DRAIN
  } front_state_e;

  typedef enum logic [1:0] {
    B_JOB,
    B_READ,
    B_LOAD,
    B_STAT
  } back_state_e;

  typedef enum logic [1:0] {
    JOB_EMIT,
    JOB_STORE,
    JOB_DRAIN
  } job_e;

  typedef struct packed {
    cmd_e                cmd;
    logic [7:0]          addr;
    logic [7:0]          opc;
    logic [TX_CNT_W-1:0] tx_cnt;
    logic [RX_CNT_W-1:0] rx_cnt;
    logic                send_crc;
    logic                check_crc;
    logic [7:0]          data;
  } item_t;

  // emit: one output word; store: reply byte at cnt; drain: cnt reply bytes then ok
  typedef struct packed {
    job_e                jkind;
    kind_e               kind;
    logic [7:0]          data;
    status_e             status;
    logic                last;
    logic [RX_CNT_W-1:0] cnt;
  } job_t;

  function automatic logic [15:0] crc16_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

/* hw/rtl/crc_framed_command_link.sv */
// top level of the crc framed command link
//
//  channel  dir  tvalid/tready       tdata                         tuser / tlast
//  s        in   s_tvalid_i/_tready  addr,opc,tx,rx,scrc,ccrc,db   tuser: command
//  m        out  m_tvalid_o/_tready  out_byte, status             tuser: out_kind, tlast: last
//
//  the front accepts one input word, then issues its jobs, one per cycle while the queue is not full;
//  a begin issues 2 to 5 jobs, a frame-ending data word up to 4
//  the back sends one emitted word per cycle while the output is not stalled, a reply drain takes
//  the job, then per byte a buffer read and a load of the output register, then the status
//  a 4-entry job queue lets the front keep accepting while the back stalls
//  reset is asynchronous and clears control state only; the reply buffer is not cleared
module crc_framed_command_link
  import cfl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  // addr[7:0] opcode[15:8] tx_count[19:16] rx_count[25:20] send_crc[26]
  // check_crc[27] data_byte[35:28] pad[39:36]
  input  logic [39:0] s_tdata_i,
  // command[1:0]
  input  logic [1:0]  s_tuser_i,
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  // out_byte[7:0] status[9:8] pad[15:10]
  output logic [15:0] m_tdata_o,
  // out_kind[1:0]
  output logic [1:0]  m_tuser_o,
  output logic        m_tlast_o
);

  item_t      item;
  job_t       push_job, pop_job;
  logic       push, full, pop, empty;
  kind_e      out_kind;
  logic [7:0] out_byte;
  status_e    out_status;

  assign item.cmd       = cmd_e'(s_tuser_i);
  assign item.addr      = s_tdata_i[7:0];
  assign item.opc       = s_tdata_i[15:8];
  assign item.tx_cnt    = s_tdata_i[19:16];
  assign item.rx_cnt    = s_tdata_i[25:20];
  assign item.send_crc  = s_tdata_i[26];
  assign item.check_crc = s_tdata_i[27];
  assign item.data      = s_tdata_i[35:28];

  cfl_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .item_i     (item),
    .push_o     (push),
    .job_o      (push_job),
    .full_i     (full)
  );

  cfl_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (full),
    .pop_i      (pop),
    .pop_job_o  (pop_job),
    .empty_o    (empty)
  );

  cfl_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_i        (pop_job),
    .empty_i      (empty),
    .pop_o        (pop),
    .m_tvalid_o   (m_tvalid_o),
    .m_tready_i   (m_tready_i),
    .out_kind_o   (out_kind),
    .out_byte_o   (out_byte),
    .out_status_o (out_status),
    .out_last_o   (m_tlast_o)
  );

  assign m_tdata_o = {6'b000000, out_status, out_byte};
  assign m_tuser_o = out_kind;

endmodule

/* hw/rtl/cfl_queue.sv */
// short job queue between the front and back parts
module cfl_queue
  import cfl_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  output logic full_o,
  input  logic pop_i,
  output job_t pop_job_o,
  output logic empty_o
);

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QPTR_W:0]   count_q, count_d;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign full_o    = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty_o   = (count_q == '0);
  assign pop_job_o = mem_q[rptr_q];

  always_comb begin
    wptr_d  = push_i ? ptr_inc(wptr_q) : wptr_q;
    rptr_d  = pop_i ? ptr_inc(rptr_q) : rptr_q;
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + (QPTR_W + 1)'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - (QPTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_job_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (QPTR_W + 1)'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("pop from empty queue");

endmodule

/* hw/rtl/cfl_front.sv */
// front part: accepts words, tracks the link phase and crc, issues jobs
module cfl_front
  import cfl_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_tvalid_i,
  output logic       s_tready_o,
  input  item_t      item_i,
  output logic       push_o,
  output job_t       job_o,
  input  logic       full_i
);

  front_state_e        fstate_q, fstate_d;
  phase_e              phase_q, phase_d;
  item_t               item_q, item_d;
  logic [15:0]         crc_q, crc_d;
  logic [TX_CNT_W-1:0] tx_left_q, tx_left_d;
  logic [RX_CNT_W-1:0] rx_exp_q, rx_exp_d;
  logic [RX_CNT_W-1:0] rx_rcv_q, rx_rcv_d;
  logic                send_q, send_d;
  logic                check_q, check_d;
  logic [7:0]          crc_hi_q, crc_hi_d;
  logic [RX_CNT_W-1:0] rx_inc;
  logic                do_tail;

  assign rx_inc = rx_rcv_q + RX_CNT_W'(1);

  always_comb begin
    fstate_d   = fstate_q;
    phase_d    = phase_q;
    item_d     = item_q;
    crc_d      = crc_q;
    tx_left_d  = tx_left_q;
    rx_exp_d   = rx_exp_q;
    rx_rcv_d   = rx_rcv_q;
    send_d     = send_q;
    check_d    = check_q;
    crc_hi_d   = crc_hi_q;
    s_tready_o = 1'b0;
    push_o     = 1'b0;
    do_tail    = 1'b0;
    job_o      = '{jkind: JOB_EMIT, kind: KIND_TX, data: 8'h00, status: ST_OK,
                   last: 1'b0, cnt: '0};

    case (fstate_q)
      F_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          item_d   = item_i;
          fstate_d = F_EXEC;
        end
      end
      F_EXEC: begin
        if (!full_i) begin
          fstate_d = F_IDLE;
          case (item_q.cmd)
            CMD_BEGIN: begin
              crc_d     = crc16_add(16'h0000, item_q.addr);
              tx_left_d = (item_q.tx_cnt > TX_CNT_W'(TX_MAX)) ? TX_CNT_W'(TX_MAX)
                                                               : item_q.tx_cnt;
              rx_exp_d  = (item_q.rx_cnt > RX_CNT_W'(RX_MAX)) ? RX_CNT_W'(RX_MAX)
                                                               : item_q.rx_cnt;
              send_d    = item_q.send_crc;
              check_d   = item_q.check_crc;
              rx_rcv_d  = '0;
              crc_hi_d  = 8'h00;
              push_o    = 1'b1;
              job_o.data = item_q.addr;
              fstate_d  = F_OPC;
            end
            CMD_DATA: begin
              if (phase_q == PH_SEND) begin
                push_o     = 1'b1;
                job_o.data = item_q.data;
                if (send_q) begin
                  crc_d = crc16_add(crc_q, item_q.data);
                end
                tx_left_d = tx_left_q - TX_CNT_W'(1);
                if (tx_left_q == TX_CNT_W'(1)) begin
                  if (send_q) begin
                    fstate_d = F_CRCH;
                  end else begin
                    do_tail = 1'b1;
                  end
                end else begin
                  job_o.last = 1'b1;
                end
              end
            end
            CMD_RXBYTE: begin
              if (phase_q == PH_RXDATA) begin
                push_o      = 1'b1;
                job_o.jkind = JOB_STORE;
                job_o.data  = item_q.data;
                job_o.cnt   = rx_rcv_q;
                crc_d       = crc16_add(crc_q, item_q.data);
                rx_rcv_d    = rx_inc;
                if (rx_inc >= rx_exp_q) begin
                  if (check_q) begin
                    phase_d  = PH_RXCRC;
                    rx_rcv_d = '0;
                  end else begin
                    fstate_d = F_DRAIN;
                  end
                end
              end else if (phase_q == PH_RXCRC) begin
                if (rx_rcv_q == '0) begin
                  crc_hi_d = item_q.data;
                  rx_rcv_d = RX_CNT_W'(1);
                end else if ({crc_hi_q, item_q.data} == crc_q) begin
                  fstate_d = F_DRAIN;
                end else begin
                  push_o       = 1'b1;
                  job_o.kind   = KIND_STATUS;
                  job_o.status = ST_CRC;
                  job_o.last   = 1'b1;
                  phase_d      = PH_IDLE;
                end
              end
            end
            CMD_TIMEOUT: begin
              if (phase_q != PH_IDLE) begin
                push_o       = 1'b1;
                job_o.kind   = KIND_STATUS;
                job_o.status = ST_TIMEOUT;
                job_o.last   = 1'b1;
                phase_d      = PH_IDLE;
              end
            end
            default: ;
          endcase
        end
      end
      F_OPC: begin
        if (!full_i) begin
          push_o     = 1'b1;
          job_o.data = item_q.opc;
          crc_d      = crc16_add(crc_q, item_q.opc);
          if (tx_left_q != '0) begin
            phase_d    = PH_SEND;
            job_o.last = 1'b1;
            fstate_d   = F_IDLE;
          end else if (send_q) begin
            fstate_d = F_CRCH;
          end else begin
            do_tail = 1'b1;
          end
        end
      end
      F_CRCH: begin
        if (!full_i) begin
          push_o     = 1'b1;
          job_o.data = crc_q[15:8];
          fstate_d   = F_CRCL;
        end
      end
      F_CRCL: begin
        if (!full_i) begin
          push_o     = 1'b1;
          job_o.data = crc_q[7:0];
          do_tail    = 1'b1;
        end
      end
      F_DRAIN: begin
        if (!full_i) begin
          push_o      = 1'b1;
          job_o.jkind = JOB_DRAIN;
          job_o.cnt   = rx_exp_q;
          phase_d     = PH_IDLE;
          fstate_d    = F_IDLE;
        end
      end
      default: fstate_d = F_IDLE;
    endcase

    // end of the transmitted frame: reply phase or immediate ok
    if (do_tail) begin
      rx_rcv_d = '0;
      if (rx_exp_q != '0) begin
        phase_d    = PH_RXDATA;
        job_o.last = 1'b1;
        fstate_d   = F_IDLE;
      end else if (check_q) begin
        phase_d    = PH_RXCRC;
        job_o.last = 1'b1;
        fstate_d   = F_IDLE;
      end else begin
        fstate_d = F_DRAIN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fstate_q  <= F_IDLE;
      phase_q   <= PH_IDLE;
      crc_q     <= '0;
      tx_left_q <= '0;
      rx_exp_q  <= '0;
      rx_rcv_q  <= '0;
      send_q    <= 1'b0;
      check_q   <= 1'b0;
      crc_hi_q  <= '0;
    end else begin
      fstate_q  <= fstate_d;
      phase_q   <= phase_d;
      crc_q     <= crc_d;
      tx_left_q <= tx_left_d;
      rx_exp_q  <= rx_exp_d;
      rx_rcv_q  <= rx_rcv_d;
      send_q    <= send_d;
      check_q   <= check_d;
      crc_hi_q  <= crc_hi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  a_one_word_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_o |=> !s_tready_o)
    else $error("front took a word while busy");

  a_send_has_bytes_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fstate_q == F_IDLE && phase_q == PH_SEND |-> tx_left_q != '0)
    else $error("sending phase with no bytes left");

endmodule

/* hw/rtl/cfl_back.sv */
// back part: runs jobs, holds the reply buffer and the output register
module cfl_back
  import cfl_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  job_t       job_i,
  input  logic       empty_i,
  output logic       pop_o,
  output logic       m_tvalid_o,
  input  logic       m_tready_i,
  output kind_e      out_kind_o,
  output logic [7:0] out_byte_o,
  output status_e    out_status_o,
  output logic       out_last_o
);

  back_state_e         bstate_q, bstate_d;
  logic [RX_CNT_W-1:0] idx_q, idx_d;
  logic [RX_CNT_W-1:0] n_q, n_d;
  logic [7:0]          store_q [RX_MAX];
  logic [7:0]          rdata_q;
  logic                wr_en, rd_en, load;
  kind_e               ld_kind;
  logic [7:0]          ld_data;
  status_e             ld_status;
  logic                ld_last;
  logic                out_valid_q;
  kind_e               out_kind_q;
  logic [7:0]          out_data_q;
  status_e             out_status_q;
  logic                out_last_q;
  logic                out_free;

  assign out_free     = !out_valid_q || m_tready_i;
  assign m_tvalid_o   = out_valid_q;
  assign out_kind_o   = out_kind_q;
  assign out_byte_o   = out_data_q;
  assign out_status_o = out_status_q;
  assign out_last_o   = out_last_q;

  always_comb begin
    bstate_d  = bstate_q;
    idx_d     = idx_q;
    n_d       = n_q;
    pop_o     = 1'b0;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    load      = 1'b0;
    ld_kind   = job_i.kind;
    ld_data   = job_i.data;
    ld_status = job_i.status;
    ld_last   = job_i.last;

    case (bstate_q)
      B_JOB: begin
        if (!empty_i) begin
          case (job_i.jkind)
            JOB_EMIT: begin
              if (out_free) begin
                load  = 1'b1;
                pop_o = 1'b1;
              end
            end
            JOB_STORE: begin
              wr_en = 1'b1;
              pop_o = 1'b1;
            end
            JOB_DRAIN: begin
              pop_o    = 1'b1;
              n_d      = job_i.cnt;
              idx_d    = '0;
              bstate_d = (job_i.cnt == '0) ? B_STAT : B_READ;
            end
            default: pop_o = 1'b1;
          endcase
        end
      end
      B_READ: begin
        rd_en    = 1'b1;
        bstate_d = B_LOAD;
      end
      B_LOAD: begin
        ld_kind   = KIND_REPLY;
        ld_data   = rdata_q;
        ld_status = ST_OK;
        ld_last   = 1'b0;
        if (out_free) begin
          load     = 1'b1;
          idx_d    = idx_q + RX_CNT_W'(1);
          bstate_d = (idx_q + RX_CNT_W'(1) == n_q) ? B_STAT : B_READ;
        end
      end
      B_STAT: begin
        ld_kind   = KIND_STATUS;
        ld_data   = 8'h00;
        ld_status = ST_OK;
        ld_last   = 1'b1;
        if (out_free) begin
          load     = 1'b1;
          bstate_d = B_JOB;
        end
      end
      default: bstate_d = B_JOB;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bstate_q    <= B_JOB;
      idx_q       <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      bstate_q <= bstate_d;
      idx_q    <= idx_d;
      n_q      <= n_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_kind_q   <= ld_kind;
      out_data_q   <= ld_data;
      out_status_q <= ld_status;
      out_last_q   <= ld_last;
    end
  end

  // reply buffer
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[job_i.cnt[RX_IDX_W-1:0]] <= job_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= store_q[idx_q[RX_IDX_W-1:0]];
    end
  end

  a_read_then_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bstate_q == B_READ |=> bstate_q == B_LOAD)
    else $error("buffer read not followed by load");

  a_drain_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= n_q && n_q <= RX_CNT_W'(RX_MAX))
    else $error("drain index out of range");

endmodule
